[design/mmfld_pkg.sv]
// Package for the min/max/first/last decimator.
// Holds field widths, command and register codes and the job record passed
// from the front end to the back end. No dependencies.
package mmfld_pkg;

    // field widths fixed by the interface
    localparam int STIME_W = 31;
    localparam int VALUE_W = 32;
    localparam int CELL_W  = 32;
    localparam int PI_W    = 31;
    localparam int CAP_W   = 11;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 1;

    // gap test: more than this many intervals beyond the interval end
    localparam int GAP_INTERVALS = 4;
    // interval end (time + interval) and gap end (interval end + four intervals)
    localparam int PEND_W  = 32;
    localparam int GEND_W  = 34;

    // emit flag bits
    localparam int FLAG_FIRST = 0;
    localparam int FLAG_LAST  = 1;
    localparam int FLAG_W     = 2;

    // cells of one job, in output order
    localparam int SLOT_FIRST = 0;
    localparam int SLOT_EARLY = 1;
    localparam int SLOT_LATE  = 2;
    localparam int SLOT_LAST  = 3;
    localparam int SLOT_MARK  = 4;
    localparam int SLOT_N     = 5;

    // job queue depth between front and back
    localparam int JOBQ_DEPTH = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA  = 2'd0,
        CMD_NULL  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACK_INTERVAL = 1'd0,
        CFG_CAPACITY      = 1'd1
    } cfg_idx_t;

    // one committed interval: up to five cells, each with a valid bit
    typedef struct packed {
        logic [SLOT_N-1:0]                     slot_valid;
        logic [SLOT_N-1:0][CELL_W-1:0]         slot_time;
        logic signed [SLOT_N-1:0][VALUE_W-1:0] slot_value;
    } job_t;

endpackage

[design/mmfld_front.sv]
// Front end of the decimator: accepts samples, keeps the interval trackers
// and turns each commit into a job record for the back end.
// Depends on mmfld_pkg.
module mmfld_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [mmfld_pkg::CMD_W-1:0]           cmd,
    input  logic [mmfld_pkg::STIME_W-1:0]         sample_time,
    input  logic signed [mmfld_pkg::VALUE_W-1:0]  sample_value,
    input  logic [mmfld_pkg::PI_W-1:0]            pack_interval,
    output logic                                  push,
    output mmfld_pkg::job_t                       job
);

    localparam int TW = mmfld_pkg::STIME_W;
    localparam int VW = mmfld_pkg::VALUE_W;
    localparam int CW = mmfld_pkg::CELL_W;

    // tracker and interval state
    logic [TW-1:0]                   first_t_reg, first_t_next;
    logic signed [VW-1:0]            first_v_reg, first_v_next;
    logic [TW-1:0]                   last_t_reg, last_t_next;
    logic signed [VW-1:0]            last_v_reg, last_v_next;
    logic [TW-1:0]                   min_t_reg, min_t_next;
    logic signed [VW-1:0]            min_v_reg, min_v_next;
    logic [TW-1:0]                   max_t_reg, max_t_next;
    logic signed [VW-1:0]            max_v_reg, max_v_next;
    logic                            open_reg, open_next;
    logic [mmfld_pkg::PEND_W-1:0]    pend_reg, pend_next;
    logic [mmfld_pkg::FLAG_W-1:0]    flags_reg, flags_next;

    logic [mmfld_pkg::GEND_W-1:0]    gap_end;
    logic                            beyond_end;
    logic                            beyond_gap;
    logic [mmfld_pkg::FLAG_W-1:0]    flags_gap;
    logic [mmfld_pkg::FLAG_W-1:0]    commit_flags;
    logic                            min_earlier;
    logic                            same_time;
    logic [TW-1:0]                   early_t, late_t;
    logic signed [VW-1:0]            early_v, late_v;
    logic                            first_ok, last_ok;
    logic                            mark_ok;

    // interval boundary tests; the gap uses the interval length in force now
    assign gap_end    = mmfld_pkg::GEND_W'(pend_reg)
                        + mmfld_pkg::GEND_W'(pack_interval)
                          * mmfld_pkg::GEND_W'(mmfld_pkg::GAP_INTERVALS);
    assign beyond_end = {1'b0, sample_time} > pend_reg;
    assign beyond_gap = mmfld_pkg::GEND_W'(sample_time) > gap_end;

    always_comb
    begin
        flags_gap = flags_reg;
        if (beyond_gap)
        begin
            flags_gap[mmfld_pkg::FLAG_LAST] = 1'b1;
        end
    end

    assign commit_flags = (mmfld_pkg::cmd_t'(cmd) == mmfld_pkg::CMD_DATA) ? flags_gap
                                                                          : flags_reg;

    // order min and max in time, one cell when they coincide
    assign min_earlier = min_t_reg < max_t_reg;
    assign same_time   = min_t_reg == max_t_reg;
    assign early_t     = same_time ? '0 : (min_earlier ? min_t_reg : max_t_reg);
    assign early_v     = min_earlier ? min_v_reg : max_v_reg;
    assign late_t      = min_earlier ? max_t_reg : min_t_reg;
    assign late_v      = min_earlier ? max_v_reg : min_v_reg;

    assign first_ok = commit_flags[mmfld_pkg::FLAG_FIRST] && (first_t_reg != '0)
                      && (first_t_reg != min_t_reg) && (first_t_reg != max_t_reg);
    assign last_ok  = commit_flags[mmfld_pkg::FLAG_LAST] && (last_t_reg != '0)
                      && (last_t_reg != min_t_reg) && (last_t_reg != early_t)
                      && (last_t_reg != max_t_reg);
    assign mark_ok  = (mmfld_pkg::cmd_t'(cmd) == mmfld_pkg::CMD_NULL) && (sample_time != '0);

    // job record built from the trackers as they stand before this sample
    always_comb
    begin
        job.slot_valid = '0;
        job.slot_valid[mmfld_pkg::SLOT_FIRST] = first_ok;
        job.slot_valid[mmfld_pkg::SLOT_EARLY] = early_t != '0;
        job.slot_valid[mmfld_pkg::SLOT_LATE]  = late_t != '0;
        job.slot_valid[mmfld_pkg::SLOT_LAST]  = last_ok;
        job.slot_valid[mmfld_pkg::SLOT_MARK]  = mark_ok;

        job.slot_time[mmfld_pkg::SLOT_FIRST] = CW'(first_t_reg);
        job.slot_time[mmfld_pkg::SLOT_EARLY] = CW'(early_t);
        job.slot_time[mmfld_pkg::SLOT_LATE]  = CW'(late_t);
        job.slot_time[mmfld_pkg::SLOT_LAST]  = CW'(last_t_reg);
        job.slot_time[mmfld_pkg::SLOT_MARK]  = CW'(0) - CW'(sample_time);

        job.slot_value[mmfld_pkg::SLOT_FIRST] = first_v_reg;
        job.slot_value[mmfld_pkg::SLOT_EARLY] = early_v;
        job.slot_value[mmfld_pkg::SLOT_LATE]  = late_v;
        job.slot_value[mmfld_pkg::SLOT_LAST]  = last_v_reg;
        job.slot_value[mmfld_pkg::SLOT_MARK]  = '0;
    end

    // next state per command
    always_comb
    begin
        first_t_next = first_t_reg;
        first_v_next = first_v_reg;
        last_t_next  = last_t_reg;
        last_v_next  = last_v_reg;
        min_t_next   = min_t_reg;
        min_v_next   = min_v_reg;
        max_t_next   = max_t_reg;
        max_v_next   = max_v_reg;
        open_next    = open_reg;
        pend_next    = pend_reg;
        flags_next   = flags_reg;
        push         = 1'b0;

        if (accept)
        begin
            case (mmfld_pkg::cmd_t'(cmd))
                mmfld_pkg::CMD_DATA:
                begin
                    if (!open_reg || beyond_end)
                    begin
                        open_next = 1'b1;
                        pend_next = mmfld_pkg::PEND_W'(sample_time)
                                    + mmfld_pkg::PEND_W'(pack_interval);
                    end
                    if (open_reg && beyond_end)
                    begin
                        // close the interval, restart trackers at this sample
                        push = 1'b1;
                        if (flags_gap[mmfld_pkg::FLAG_LAST])
                        begin
                            flags_next = '0;
                            flags_next[mmfld_pkg::FLAG_FIRST] = 1'b1;
                        end
                        else
                        begin
                            flags_next = flags_gap;
                        end
                        first_t_next = sample_time;
                        first_v_next = sample_value;
                        last_t_next  = sample_time;
                        last_v_next  = sample_value;
                        min_t_next   = sample_time;
                        min_v_next   = sample_value;
                        max_t_next   = sample_time;
                        max_v_next   = sample_value;
                    end
                    else
                    begin
                        // plain tracking inside the interval
                        if (first_t_reg == '0)
                        begin
                            first_t_next = sample_time;
                            first_v_next = sample_value;
                        end
                        last_t_next = sample_time;
                        last_v_next = sample_value;
                        if ((min_t_reg == '0) || (sample_value < min_v_reg))
                        begin
                            min_t_next = sample_time;
                            min_v_next = sample_value;
                        end
                        if ((max_t_reg == '0) || (max_v_reg < sample_value))
                        begin
                            max_t_next = sample_time;
                            max_v_next = sample_value;
                        end
                    end
                end
                mmfld_pkg::CMD_NULL, mmfld_pkg::CMD_FLUSH:
                begin
                    push         = 1'b1;
                    open_next    = 1'b0;
                    flags_next   = '0;
                    first_t_next = '0;
                    first_v_next = '0;
                    last_t_next  = '0;
                    last_v_next  = '0;
                    min_t_next   = '0;
                    min_v_next   = '0;
                    max_t_next   = '0;
                    max_v_next   = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_t_reg <= '0;
            first_v_reg <= '0;
            last_t_reg  <= '0;
            last_v_reg  <= '0;
            min_t_reg   <= '0;
            min_v_reg   <= '0;
            max_t_reg   <= '0;
            max_v_reg   <= '0;
            open_reg    <= 1'b0;
            pend_reg    <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            first_t_reg <= first_t_next;
            first_v_reg <= first_v_next;
            last_t_reg  <= last_t_next;
            last_v_reg  <= last_v_next;
            min_t_reg   <= min_t_next;
            min_v_reg   <= min_v_next;
            max_t_reg   <= max_t_next;
            max_v_reg   <= max_v_next;
            open_reg    <= open_next;
            pend_reg    <= pend_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

[design/mmfld_job_queue.sv]
// Short job queue between the front and back ends of the decimator.
// Flop storage, head read directly, push and pop in the same cycle allowed.
// Depends on mmfld_pkg.
module mmfld_job_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mmfld_pkg::job_t push_job,
    input  logic            pop,
    output mmfld_pkg::job_t head_job,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmfld_pkg::job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    do_push, do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // the front end never offers a job while the queue is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count beyond depth");

endmodule

[design/mmfld_back.sv]
// Back end of the decimator: walks the cells of each queued job into the
// output register, counts emitted cells and halts at capacity.
// Depends on mmfld_pkg.
module mmfld_back
#(
    parameter int MAX_CELLS = 1024
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [mmfld_pkg::CAP_W-1:0]           capacity,
    input  mmfld_pkg::job_t                       head_job,
    input  logic                                  head_valid,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mmfld_pkg::CELL_W-1:0]   cell_time,
    output logic signed [mmfld_pkg::VALUE_W-1:0]  cell_value,
    output logic                                  last_of_run,
    output logic                                  store_full
);

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int LIM_W = (CNT_W > mmfld_pkg::CAP_W) ? CNT_W : mmfld_pkg::CAP_W;
    localparam int SN    = mmfld_pkg::SLOT_N;

    logic [SN-1:0]                         done_reg, done_next;
    logic [CNT_W-1:0]                      count_reg, count_next;
    logic                                  halted_reg, halted_next;
    logic                                  out_valid_reg, out_valid_next;
    logic signed [mmfld_pkg::CELL_W-1:0]   time_reg, time_next;
    logic signed [mmfld_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic                                  last_reg, last_next;
    logic                                  full_reg, full_next;

    logic [LIM_W-1:0]                      cap_limit;
    logic                                  at_cap;
    logic                                  reach_cap;
    logic                                  can_load;
    logic [SN-1:0]                         remaining;
    logic [SN-1:0]                         sel;
    logic [SN-1:0]                         rest;
    logic [mmfld_pkg::CELL_W-1:0]          sel_time;
    logic [mmfld_pkg::VALUE_W-1:0]         sel_value;

    // capacity clipped to the storage limit
    assign cap_limit = (LIM_W'(capacity) > LIM_W'(MAX_CELLS)) ? LIM_W'(MAX_CELLS)
                                                              : LIM_W'(capacity);
    assign at_cap    = LIM_W'(count_reg) >= cap_limit;
    assign reach_cap = (LIM_W'(count_reg) + 1'b1) >= cap_limit;
    assign can_load  = !out_valid_reg || !out_stall;

    // next cell of the head job: lowest slot not yet sent
    assign remaining = head_job.slot_valid & ~done_reg;
    assign sel       = remaining & (~remaining + 1'b1);
    assign rest      = remaining & ~sel;

    always_comb
    begin
        sel_time  = '0;
        sel_value = '0;
        for (int i = 0; i < SN; i++)
        begin
            if (sel[i])
            begin
                sel_time  = sel_time | head_job.slot_time[i];
                sel_value = sel_value | head_job.slot_value[i];
            end
        end
    end

    // job walk, capacity and output register
    always_comb
    begin
        pop            = 1'b0;
        done_next      = done_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && out_stall;
        time_next      = time_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        full_next      = full_reg;

        if (head_valid)
        begin
            if (halted_reg)
            begin
                // drop everything once halted
                pop       = 1'b1;
                done_next = '0;
            end
            else if (at_cap)
            begin
                halted_next = 1'b1;
                pop         = 1'b1;
                done_next   = '0;
            end
            else if (remaining == '0)
            begin
                pop       = 1'b1;
                done_next = '0;
            end
            else if (can_load)
            begin
                out_valid_next = 1'b1;
                time_next      = sel_time;
                value_next     = sel_value;
                count_next     = count_reg + 1'b1;
                full_next      = reach_cap;
                halted_next    = reach_cap;
                last_next      = reach_cap || (rest == '0);
                if (reach_cap || (rest == '0))
                begin
                    pop       = 1'b1;
                    done_next = '0;
                end
                else
                begin
                    done_next = done_reg | sel;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        full_reg  <= full_next;
    end

    assign out_valid   = out_valid_reg;
    assign cell_time   = time_reg;
    assign cell_value  = value_reg;
    assign last_of_run = last_reg;
    assign store_full  = full_reg;

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_full_means_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_reg) |-> halted_reg)
        else $error("full cell shown while not halted");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CELLS))
        else $error("cell count beyond storage limit");

endmodule

[design/min_max_first_last_decimator_core.sv]
// Channel      Direction  Handshake            Payload
// input        in         in_valid / in_stall  cmd, sample_time, sample_value
// output       out        out_valid/out_stall  cell_time, cell_value, last_of_run, store_full
// config       in         cfg_wr_en            cfg_index, cfg_wr_data
//
// One sample is taken per cycle while the job queue has room. A commit
// becomes one job; the back end emits its cells one at a time and pops the
// job with its last cell, or at once when it has none, so the queue depth
// sets how long a burst of commits is absorbed before in_stall rises.
// Reset clears trackers, flags, cell count and the halt; config returns to
// an interval of 1 and a capacity of 1024. out_stall only holds the output
// register and, once the queue fills, the input.
module min_max_first_last_decimator_core
#(
    parameter int MAX_CELLS = 1024
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [mmfld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmfld_pkg::CFG_W-1:0]           cfg_wr_data,
    // sample input
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mmfld_pkg::CMD_W-1:0]           cmd,
    input  logic [mmfld_pkg::STIME_W-1:0]         sample_time,
    input  logic signed [mmfld_pkg::VALUE_W-1:0]  sample_value,
    // cell output
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mmfld_pkg::CELL_W-1:0]   cell_time,
    output logic signed [mmfld_pkg::VALUE_W-1:0]  cell_value,
    output logic                                  last_of_run,
    output logic                                  store_full
);

    logic [mmfld_pkg::PI_W-1:0]   pi_reg;
    logic [mmfld_pkg::CAP_W-1:0]  cap_reg;

    logic                         in_accept;
    logic                         push;
    mmfld_pkg::job_t              push_job;
    mmfld_pkg::job_t              head_job;
    logic                         q_empty;
    logic                         q_full;
    logic                         pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg  <= mmfld_pkg::PI_W'(1);
            cap_reg <= mmfld_pkg::CAP_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            case (mmfld_pkg::cfg_idx_t'(cfg_index))
                mmfld_pkg::CFG_PACK_INTERVAL:
                begin
                    pi_reg <= cfg_wr_data[mmfld_pkg::PI_W-1:0];
                end
                mmfld_pkg::CFG_CAPACITY:
                begin
                    cap_reg <= cfg_wr_data[mmfld_pkg::CAP_W-1:0];
                end
                default:
                begin
                    cap_reg <= cap_reg;
                end
            endcase
        end
    end

    // input transfer whenever the job queue has room
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    mmfld_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .cmd              (cmd),
        .sample_time      (sample_time),
        .sample_value     (sample_value),
        .pack_interval    (pi_reg),
        .push             (push),
        .job              (push_job)
    );

    mmfld_job_queue
    #(
        .DEPTH (mmfld_pkg::JOBQ_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    mmfld_back
    #(
        .MAX_CELLS (MAX_CELLS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (cap_reg),
        .head_job    (head_job),
        .head_valid  (!q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_time   (cell_time),
        .cell_value  (cell_value),
        .last_of_run (last_of_run),
        .store_full  (store_full)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for min_max_first_last_decimator_core.
// Depends on mmfld_pkg and the core; predicts every emitted cell from the
// accepted samples and checks each output transfer against the oldest one due.
module tb;

    localparam int MAX_CELLS  = 1024;
    localparam int SETTLE     = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [30:0] TIME_TOP = 31'h7fff_ffff;

    typedef struct {
        logic [mmfld_pkg::CELL_W-1:0]         t;
        logic signed [mmfld_pkg::VALUE_W-1:0] v;
        bit                                   end_of_run;
        bit                                   full;
    } cell_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [mmfld_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [mmfld_pkg::CFG_W-1:0]          cfg_wr_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [mmfld_pkg::CMD_W-1:0]          cmd = '0;
    logic [mmfld_pkg::STIME_W-1:0]        sample_time = '0;
    logic signed [mmfld_pkg::VALUE_W-1:0] sample_value = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [mmfld_pkg::CELL_W-1:0]  cell_time;
    logic signed [mmfld_pkg::VALUE_W-1:0] cell_value;
    logic                                 last_of_run;
    logic                                 store_full;

    // predictor state and register mirror
    logic [31:0]                          fst_t, lst_t, mn_t, mx_t;
    logic signed [31:0]                   fst_v, lst_v, mn_v, mx_v;
    bit                                   span_open;
    longint unsigned                      span_end;
    logic [mmfld_pkg::FLAG_W-1:0]         flags;
    int unsigned                          cells_out;
    bit                                   halted;
    longint unsigned                      iv_mirror = 1;
    int unsigned                          cap_mirror = 1024;

    cell_t                                run_cells[$];
    cell_t                                due_cells[$];
    cell_t                                want;

    int unsigned                          samples_in, cells_seen, errors;
    int unsigned                          out_hold, idle_cycles;
    bit                                   in_quiet, out_quiet;

    min_max_first_last_decimator_core #(.MAX_CELLS(MAX_CELLS)) dut (.*);

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // ---------------- predictor ----------------
    function automatic int unsigned cap_limit();
        return (cap_mirror > MAX_CELLS) ? MAX_CELLS : cap_mirror;
    endfunction

    function automatic void empty_trackers();
        fst_t = '0; fst_v = '0; lst_t = '0; lst_v = '0;
        mn_t = '0; mn_v = '0; mx_t = '0; mx_v = '0;
    endfunction

    function automatic void note_sample(logic [30:0] t, logic signed [31:0] v);
        if (fst_t == 0)
        begin
            fst_t = t;
            fst_v = v;
        end
        lst_t = t;
        lst_v = v;
        if (mn_t == 0 || v < mn_v)
        begin
            mn_t = t;
            mn_v = v;
        end
        if (mx_t == 0 || mx_v < v)
        begin
            mx_t = t;
            mx_v = v;
        end
    endfunction

    // one cell out; returns 0 once capacity is reached
    function automatic bit emit_cell(logic [31:0] t, logic signed [31:0] v);
        cell_t c;
        cells_out++;
        if (cells_out >= cap_limit())
            halted = 1'b1;
        c.t = t;
        c.v = v;
        c.end_of_run = 1'b0;
        c.full = halted;
        run_cells.push_back(c);
        return !halted;
    endfunction

    // commit the open interval: optional first, min/max in time order, optional last
    function automatic bit close_interval(logic [mmfld_pkg::FLAG_W-1:0] f);
        bit ok;
        logic [31:0] early_t, late_t;
        logic signed [31:0] early_v, late_v;
        ok = 1'b1;
        if (cells_out >= cap_limit())
        begin
            halted = 1'b1;
            empty_trackers();
            return 1'b0;
        end
        if (f[mmfld_pkg::FLAG_FIRST] && fst_t != 0 && fst_t != mn_t && fst_t != mx_t)
            ok = emit_cell(fst_t, fst_v);
        if (mn_t < mx_t)
        begin
            early_t = mn_t; early_v = mn_v; late_t = mx_t; late_v = mx_v;
        end
        else
        begin
            early_t = mx_t; early_v = mx_v; late_t = mn_t; late_v = mn_v;
        end
        if (mn_t == mx_t)
            early_t = '0;
        if (ok && early_t != 0)
            ok = emit_cell(early_t, early_v);
        if (ok && late_t != 0)
            ok = emit_cell(late_t, late_v);
        if (ok && f[mmfld_pkg::FLAG_LAST] && lst_t != 0 && lst_t != mn_t
            && lst_t != early_t && lst_t != mx_t)
            ok = emit_cell(lst_t, lst_v);
        empty_trackers();
        return ok;
    endfunction

    function automatic void decimate_sample(mmfld_pkg::cmd_t op, logic [30:0] t,
                                            logic signed [31:0] v);
        run_cells.delete();
        if (halted || op == mmfld_pkg::CMD_NONE)
            return;
        case (op)
            mmfld_pkg::CMD_DATA:
            begin
                if (!span_open)
                begin
                    span_open = 1'b1;
                    span_end = t + iv_mirror;
                    note_sample(t, v);
                end
                else if (t > span_end)
                begin
                    if (t - span_end > mmfld_pkg::GAP_INTERVALS * iv_mirror)
                        flags[mmfld_pkg::FLAG_LAST] = 1'b1;
                    if (close_interval(flags))
                    begin
                        span_end = t + iv_mirror;
                        if (flags[mmfld_pkg::FLAG_LAST])
                        begin
                            flags = '0;
                            flags[mmfld_pkg::FLAG_FIRST] = 1'b1;
                        end
                        note_sample(t, v);
                    end
                end
                else
                    note_sample(t, v);
            end
            mmfld_pkg::CMD_NULL:
            begin
                if (close_interval(flags) && t != 0)
                    void'(emit_cell(32'd0 - {1'b0, t}, '0));
                span_open = 1'b0;
                flags = '0;
            end
            mmfld_pkg::CMD_FLUSH:
            begin
                void'(close_interval(flags));
                span_open = 1'b0;
                flags = '0;
            end
            default: ;
        endcase
        if (run_cells.size() > 0)
            run_cells[run_cells.size() - 1].end_of_run = 1'b1;
        foreach (run_cells[i])
            due_cells.push_back(run_cells[i]);
    endfunction

    // ---------------- stimulus helpers ----------------
    // one input transfer, then update the prediction
    task automatic send_sample(mmfld_pkg::cmd_t op, logic [30:0] stamp,
                               logic signed [31:0] level);
        int gap;
        if ($urandom_range(0, 29) == 0)
            in_quiet = !in_quiet;
        gap = draw_wait(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        sample_time <= stamp;
        sample_value <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_in++;
        decimate_sample(op, stamp, level);
    endtask

    // wait for every due cell, then let zero-cell jobs finish
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (due_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(mmfld_pkg::cfg_idx_t idx, logic [mmfld_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        if (idx == mmfld_pkg::CFG_PACK_INTERVAL)
            iv_mirror = val;
        else
            cap_mirror = val[mmfld_pkg::CAP_W-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // mostly a time-ordered stream; some nulls, flushes, gaps and noise
    task automatic send_stream_item(ref longint unsigned stamp);
        int unsigned pick;
        longint unsigned span, stride;
        logic signed [31:0] level;
        pick = $urandom_range(0, 99);
        span = (iv_mirror == 0) ? 4 : ((iv_mirror > 100000) ? 100000 : iv_mirror);
        level = pick_level();
        if (pick < 70)
            stride = $urandom_range(0, 2 * span);
        else if (pick < 78)
            stride = (mmfld_pkg::GAP_INTERVALS + 1) * span + $urandom_range(1, span);
        else
            stride = $urandom_range(0, span);
        if (stamp + stride > TIME_TOP)
        begin
            send_sample(mmfld_pkg::CMD_FLUSH, 31'(stamp), level);
            stamp = $urandom_range(1, 1000);
            return;
        end
        stamp += stride;
        if (pick < 78)
            send_sample(mmfld_pkg::CMD_DATA, 31'(stamp), level);
        else if (pick < 84)
            send_sample(mmfld_pkg::CMD_NULL, 31'(stamp), level);
        else if (pick < 88)
            send_sample(mmfld_pkg::CMD_FLUSH, 31'(stamp), level);
        else if (pick < 91)
            send_sample(mmfld_pkg::CMD_NONE, 31'($urandom()), $urandom());
        else if (pick < 97)
            send_sample(mmfld_pkg::CMD_DATA, 31'($urandom()), level);
        else
            send_sample(mmfld_pkg::CMD_DATA, '0, level);
    endtask

    // ---------------- tests ----------------
    // reset values: interval 1, capacity 1024
    task automatic test_defaults();
        send_sample(mmfld_pkg::CMD_DATA, 31'd1, 32'sd0);
        send_sample(mmfld_pkg::CMD_DATA, 31'd2, -32'sd1);
        send_sample(mmfld_pkg::CMD_DATA, 31'd9, 32'sd5);
        send_sample(mmfld_pkg::CMD_FLUSH, 31'd9, 32'sd0);
    endtask

    // ordering of min and max, first and last after a long gap, nulls, flush,
    // unused command, time zero and value extremes
    task automatic test_directed_cases();
        drain_pipeline();
        write_reg(mmfld_pkg::CFG_PACK_INTERVAL, 31'd10);
        write_reg(mmfld_pkg::CFG_CAPACITY, 31'd2047);
        send_sample(mmfld_pkg::CMD_DATA, 31'd100, 32'sd5);
        send_sample(mmfld_pkg::CMD_DATA, 31'd103, 32'sh8000_0000);
        send_sample(mmfld_pkg::CMD_DATA, 31'd106, 32'sh7fff_ffff);
        send_sample(mmfld_pkg::CMD_DATA, 31'd108, 32'sd7);
        send_sample(mmfld_pkg::CMD_DATA, 31'd111, 32'sd1);
        send_sample(mmfld_pkg::CMD_DATA, 31'd200, 32'sd3);
        send_sample(mmfld_pkg::CMD_DATA, 31'd205, 32'sd9);
        send_sample(mmfld_pkg::CMD_DATA, 31'd207, -32'sd9);
        send_sample(mmfld_pkg::CMD_DATA, 31'd215, 32'sd0);
        send_sample(mmfld_pkg::CMD_NONE, 31'd216, 32'sd1);
        send_sample(mmfld_pkg::CMD_NULL, 31'd220, 32'sd4);
        send_sample(mmfld_pkg::CMD_NULL, 31'd0, 32'sd0);
        send_sample(mmfld_pkg::CMD_DATA, 31'd0, 32'sd4);
        send_sample(mmfld_pkg::CMD_DATA, 31'd3, 32'sd2);
        send_sample(mmfld_pkg::CMD_FLUSH, 31'd4, 32'sd0);
        send_sample(mmfld_pkg::CMD_DATA, TIME_TOP, -32'sd1);
        send_sample(mmfld_pkg::CMD_NULL, TIME_TOP, 32'sd0);
    endtask

    // interval of zero: every later sample closes the interval
    task automatic test_zero_interval();
        drain_pipeline();
        write_reg(mmfld_pkg::CFG_PACK_INTERVAL, 31'd0);
        send_sample(mmfld_pkg::CMD_DATA, 31'd50, 32'sd1);
        send_sample(mmfld_pkg::CMD_DATA, 31'd50, 32'sd2);
        send_sample(mmfld_pkg::CMD_DATA, 31'd60, -32'sd3);
        send_sample(mmfld_pkg::CMD_NULL, 31'd61, 32'sd0);
    endtask

    // widest interval: interval end beyond the time field
    task automatic test_wide_interval();
        drain_pipeline();
        write_reg(mmfld_pkg::CFG_PACK_INTERVAL, 31'h7fff_ffff);
        send_sample(mmfld_pkg::CMD_DATA, 31'd5, 32'sd8);
        send_sample(mmfld_pkg::CMD_DATA, TIME_TOP, -32'sd8);
        send_sample(mmfld_pkg::CMD_FLUSH, TIME_TOP, 32'sd0);
    endtask

    // random streams over several interval and capacity settings
    task automatic test_random_streams();
        longint unsigned stamp;
        longint unsigned iv_set[5];
        iv_set[0] = 1;
        iv_set[1] = $urandom_range(2, 20);
        iv_set[2] = 0;
        iv_set[3] = $urandom_range(100, 5000);
        iv_set[4] = $urandom_range(21, 99);
        foreach (iv_set[p])
        begin
            drain_pipeline();
            write_reg(mmfld_pkg::CFG_PACK_INTERVAL, 31'(iv_set[p]));
            write_reg(mmfld_pkg::CFG_CAPACITY, (p % 2 == 0) ? 31'd1024 : 31'd2047);
            stamp = $urandom_range(1, 1000);
            for (int i = 0; i < 72 && cells_out < 900; i++)
                send_stream_item(stamp);
        end
    endtask

    // capacity reached: output stops for good and later samples are ignored
    task automatic test_capacity_halt();
        longint unsigned stamp;
        int tries;
        drain_pipeline();
        write_reg(mmfld_pkg::CFG_PACK_INTERVAL, 31'($urandom_range(1, 6)));
        // a capacity at or below the count halts at the next commit without output
        if ($urandom_range(0, 3) == 0)
            write_reg(mmfld_pkg::CFG_CAPACITY, 31'd1);
        else
            write_reg(mmfld_pkg::CFG_CAPACITY, 31'(cells_out + $urandom_range(1, 8)));
        stamp = $urandom_range(1, 1000);
        for (tries = 0; tries < 300 && !halted; tries++)
            send_stream_item(stamp);
        for (int i = 0; i < 12; i++)
            send_stream_item(stamp);
    endtask

    // ---------------- output side ----------------
    // check each output transfer and stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            cells_seen++;
            if (due_cells.size() == 0)
                report_mismatch($sformatf("unexpected cell time %0d value %0d",
                                          cell_time, cell_value));
            else
            begin
                want = due_cells.pop_front();
                if (cell_time !== want.t)
                    report_mismatch($sformatf("cell_time %0d, want %0d",
                                              cell_time, $signed(want.t)));
                if (cell_value !== want.v)
                    report_mismatch($sformatf("cell_value %0d, want %0d",
                                              cell_value, want.v));
                if (last_of_run !== want.end_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              last_of_run, want.end_of_run));
                if (store_full !== want.full)
                    report_mismatch($sformatf("store_full %b, want %b",
                                              store_full, want.full));
            end
            if ($urandom_range(0, 29) == 0)
                out_quiet = !out_quiet;
            out_hold = draw_wait(out_quiet);
        end
        else if (out_hold > 0)
            out_hold--;
        out_stall <= (out_hold != 0);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        empty_trackers();
        span_open = 1'b0;
        span_end = 0;
        flags = '0;
        cells_out = 0;
        halted = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_directed_cases();
        test_zero_interval();
        test_wide_interval();
        test_random_streams();
        test_capacity_halt();
        drain_pipeline();
        $display("Run covered %0d accepted samples and %0d checked cells", samples_in,
                 cells_seen);
        $display("Output %s by capacity; %0d mismatches", halted ? "stopped" : "not stopped",
                 errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
